@@ hw/rtl/nrcr_pkg.sv @@
package nrcr_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // |n| << FRAC_BITS, and the shifted product magnitude
  localparam int DVD_BITS  = WORD_BITS + FRAC_BITS;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int TOL_BITS  = 16;
  localparam int STEP_BITS = 8;
  localparam int ADDR_BITS = 4;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        umag_t;

  typedef enum logic [1:0] {
    ST_CONVERGED  = 2'd0,
    ST_LIMIT      = 2'd1,
    ST_ZERO_DERIV = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_LINEAR   = 2'd0,
    REG_CONSTANT = 2'd1,
    REG_TOL      = 2'd2,
    REG_LIMIT    = 2'd3
  } reg_idx_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic [DVD_BITS-1:0] POS_LIMIT =
    {{(DVD_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic [DVD_BITS-1:0] NEG_LIMIT =
    {{(DVD_BITS-WORD_BITS){1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};

  function automatic word_t sat_add(word_t p, word_t q);
    logic [WORD_BITS:0] s;
    s = {p[WORD_BITS-1], p} + {q[WORD_BITS-1], q};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sat_sub(word_t p, word_t q);
    logic [WORD_BITS:0] s;
    s = {p[WORD_BITS-1], p} - {q[WORD_BITS-1], q};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  // magnitude; the most negative word maps to 2^(WORD_BITS-1)
  function automatic umag_t mag(word_t v);
    umag_t u;
    u = umag_t'(v);
    return v[WORD_BITS-1] ? (~u + 1'b1) : u;
  endfunction

  // sign + magnitude back to a saturated word
  function automatic word_t mag_to_word(logic [DVD_BITS-1:0] m, logic neg);
    umag_t lo;
    lo = m[WORD_BITS-1:0];
    if (!neg) begin
      return (m > POS_LIMIT) ? WORD_MAX : word_t'(lo);
    end
    return (m >= NEG_LIMIT) ? WORD_MIN : word_t'(~lo + 1'b1);
  endfunction

endpackage

@@ hw/rtl/nrcr_if.sv @@
interface nrcr_in_if import nrcr_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t start_guess;

  modport source(output valid, output start_guess, input ready);
  modport sink(input valid, input start_guess, output ready);
endinterface

interface nrcr_out_if import nrcr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  word_t                root_estimate;
  status_t              status;
  logic [STEP_BITS-1:0] steps_taken;

  modport source(output valid, output root_estimate, output status, output steps_taken,
                 input ready);
  modport sink(input valid, input root_estimate, input status, input steps_taken,
               output ready);
endinterface

@@ hw/rtl/newton_raphson_cubic_root.sv @@
// Each Newton step runs the multiply/add states (S_SQ, S_X2, S_CUBE, S_AX, S_FX),
//   the 48-bit radix-2 divider and an update (S_UPD); a zero-derivative exit
//   leaves from S_AX without dividing.
// One guess at a time: the next guess is taken once the result is in the
//   output register.
// Reset (rst, sync, active high): idle, no result pending, registers at defaults.
module newton_raphson_cubic_root import nrcr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  nrcr_in_if.sink              guess,
  nrcr_out_if.source           root,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_X2, S_CUBE, S_AX, S_FX, S_DIV, S_UPD, S_DONE
  } state_t;

  // ---------------- configuration registers ----------------
  word_t                linear_coef;
  word_t                constant_coef;
  logic [TOL_BITS-1:0]  tolerance;
  logic [STEP_BITS-1:0] iteration_limit;

  reg_idx_t reg_sel;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_coef     <= -word_t'(262144);    // -4.0
      constant_coef   <= -word_t'(589824);    // -9.0
      tolerance       <= TOL_BITS'(7);
      iteration_limit <= STEP_BITS'(100);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_LINEAR:   linear_coef     <= word_t'(pwdata);
        REG_CONSTANT: constant_coef   <= word_t'(pwdata);
        REG_TOL:      tolerance       <= pwdata[TOL_BITS-1:0];
        REG_LIMIT:    iteration_limit <= pwdata[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LINEAR:   prdata = 32'(linear_coef);
      REG_CONSTANT: prdata = 32'(constant_coef);
      REG_TOL:      prdata = {{(32-TOL_BITS){1'b0}}, tolerance};
      REG_LIMIT:    prdata = {{(32-STEP_BITS){1'b0}}, iteration_limit};
      default:      prdata = '0;
    endcase
  end

  // ---------------- datapath registers ----------------
  state_t               state;
  word_t                x;          // current estimate
  word_t                x2;         // x*x
  word_t                cube;       // x2*x
  word_t                dval;       // f'(x)
  word_t                qval;       // f/f'
  logic [STEP_BITS-1:0] iter;
  logic [STEP_BITS-1:0] limit_eff;
  logic [PROD_BITS-1:0] prod;
  logic                 prod_neg;
  status_t              fin_status;

  logic                 res_valid;
  word_t                res_root;
  status_t              res_status;
  logic [STEP_BITS-1:0] res_steps;

  // ---------------- shared multiplier ----------------
  // One 32x32 magnitude multiplier serves x*x, x2*x and a*x in turn.
  umag_t mul_a, mul_b;
  logic  mul_neg;

  always_comb begin
    mul_a   = mag(x);
    mul_b   = mag(x);
    mul_neg = 1'b0;
    case (state)
      S_CUBE: begin
        mul_a   = mag(x2);
        mul_neg = x2[WORD_BITS-1] ^ x[WORD_BITS-1];
      end
      S_AX: begin
        mul_a   = mag(linear_coef);
        mul_neg = linear_coef[WORD_BITS-1] ^ x[WORD_BITS-1];
      end
      default: ;
    endcase
  end

  // product back to Q16.16, truncated toward zero, saturated
  word_t prod_word;
  assign prod_word = mag_to_word(prod[PROD_BITS-1:FRAC_BITS], prod_neg);

  // f'(x) = (x2 + x2) + (x2 + a), each add saturating
  word_t d_comb;
  assign d_comb = sat_add(sat_add(x2, x2), sat_add(x2, linear_coef));

  // f(x) = (x^3 + a*x) + b; a*x is the product in flight during S_FX
  word_t fx_comb;
  assign fx_comb = sat_add(sat_add(cube, prod_word), constant_coef);

  // ---------------- divider ----------------
  logic  div_done;
  word_t div_quo;

  nrcr_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(state == S_FX),
    .num  (fx_comb),
    .den  (dval),
    .done (div_done),
    .quo  (div_quo)
  );

  // ---------------- update and step-size test ----------------
  word_t              x1;
  logic [WORD_BITS:0] delta;
  logic [WORD_BITS:0] step_abs;
  logic               converged;

  always_comb begin
    x1        = sat_sub(x, qval);
    delta     = {x1[WORD_BITS-1], x1} - {x[WORD_BITS-1], x};
    step_abs  = delta[WORD_BITS] ? (~delta + 1'b1) : delta;
    converged = step_abs < {{(WORD_BITS+1-TOL_BITS){1'b0}}, tolerance};
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (root.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (guess.valid) begin
            x         <= guess.start_guess;
            iter      <= STEP_BITS'(1);
            limit_eff <= (iteration_limit == '0) ? STEP_BITS'(1) : iteration_limit;
            state     <= S_SQ;
          end
        end
        S_SQ: begin
          prod     <= mul_a * mul_b;
          prod_neg <= mul_neg;
          state    <= S_X2;
        end
        S_X2: begin
          x2    <= prod_word;
          state <= S_CUBE;
        end
        S_CUBE: begin
          prod     <= mul_a * mul_b;
          prod_neg <= mul_neg;
          dval     <= d_comb;
          state    <= S_AX;
        end
        S_AX: begin
          if (dval == '0) begin
            // flat tangent: stop with the current estimate
            fin_status <= ST_ZERO_DERIV;
            state      <= S_DONE;
          end else begin
            cube     <= prod_word;
            prod     <= mul_a * mul_b;
            prod_neg <= mul_neg;
            state    <= S_FX;
          end
        end
        S_FX: begin
          state <= S_DIV;   // divider loads f and f' this cycle
        end
        S_DIV: begin
          if (div_done) begin
            qval  <= div_quo;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          x <= x1;
          if (converged) begin
            fin_status <= ST_CONVERGED;
            state      <= S_DONE;
          end else if (iter == limit_eff) begin
            fin_status <= ST_LIMIT;
            state      <= S_DONE;
          end else begin
            iter  <= iter + 1'b1;
            state <= S_SQ;
          end
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!res_valid || root.ready) begin
            res_valid  <= 1'b1;
            res_root   <= x;
            res_status <= fin_status;
            res_steps  <= iter;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign guess.ready        = (state == S_IDLE);
  assign root.valid         = res_valid;
  assign root.root_estimate = res_root;
  assign root.status        = res_status;
  assign root.steps_taken   = res_steps;

  // ---------------- assertions ----------------
  a_div_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide wait");

  a_iter_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (iter != '0 && iter <= limit_eff))
    else $error("step counter outside 1..limit");

  a_limit_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && fin_status == ST_LIMIT) |-> iter == limit_eff)
    else $error("limit status before the step limit");

endmodule

@@ hw/rtl/nrcr_div.sv @@
// Radix-2 restoring divider: quo = sat((num << FRAC_BITS) / den), toward zero.
module nrcr_div import nrcr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t num,
  input  word_t den,
  output logic  done,
  output word_t quo
);

  localparam int CNT_BITS = $clog2(DVD_BITS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(DVD_BITS - 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  umag_t               rem;
  umag_t               dmag;
  logic [DVD_BITS-1:0] dvd;  // dividend bits out the top, quotient bits in the bottom
  logic                neg;

  logic [WORD_BITS:0]  rem_sh;
  logic [WORD_BITS:0]  rem_sub;
  logic                qbit;

  always_comb begin
    rem_sh  = {rem, dvd[DVD_BITS-1]};
    rem_sub = rem_sh - {1'b0, dmag};
    qbit    = (rem_sh >= {1'b0, dmag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dmag <= mag(den);
        neg  <= num[WORD_BITS-1] ^ den[WORD_BITS-1];
        dvd  <= {mag(num), {FRAC_BITS{1'b0}}};
      end else if (busy) begin
        rem <= qbit ? rem_sub[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
        dvd <= {dvd[DVD_BITS-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quo = mag_to_word(dvd, neg);

endmodule
